// File: rtl/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_WRITE  = 3'd4;
    localparam logic [2:0] ACT_SEARCH = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic signed [7:0] FIDX_NONE = -8'sd1;

    // index register update
    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_POS  = 3'd1;
    localparam logic [2:0] IDX_CNT  = 3'd2;
    localparam logic [2:0] IDX_ZERO = 3'd3;
    localparam logic [2:0] IDX_INC  = 3'd4;
    localparam logic [2:0] IDX_DEC  = 3'd5;

    // memory read address
    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_IDX_P1 = 2'd2;
    localparam logic [1:0] RD_POS    = 2'd3;

    // memory write address and data
    localparam logic [1:0] WR_CNT_VAL = 2'd0;
    localparam logic [1:0] WR_POS_VAL = 2'd1;
    localparam logic [1:0] WR_IDX_RD  = 2'd2;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    // found index source
    localparam logic [1:0] FX_ZERO = 2'd0;
    localparam logic [1:0] FX_IDX  = 2'd1;
    localparam logic [1:0] FX_NONE = 2'd2;

    typedef struct packed {
        logic       capture;
        logic [2:0] idx_sel;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic [1:0] cnt_op;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_read;
        logic [1:0] out_fidx;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic       full;
        logic       ins_bad;
        logic       pos_bad;
        logic       idx_gt_pos;
        logic       idx_p1_lt_cnt;
        logic       idx_lt_cnt;
        logic       match;
        logic       out_free;
    } t_stat;

endpackage

// File: rtl/pls_if.sv
`timescale 1ns / 1ps

interface pls_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
    logic signed [31:0] search_key;

    modport source (output valid, action, position, value, search_key, input ready);
    modport sink   (input valid, action, position, value, search_key, output ready);
endinterface

interface pls_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic signed [7:0]  found_index;
    logic [7:0]         fill_count;

    modport source (output valid, status, read_value, found_index, fill_count, input ready);
    modport sink   (input valid, status, read_value, found_index, fill_count, output ready);
endinterface

// File: rtl/positional_list_store.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words in a memory with one write
// port and one registered read port, one request at a time, one response per
// request. Append, write, rejected requests and unused action codes finish in
// the decode state; read goes on through a done state. Insert and delete move
// one entry at a time, a read and then a write through the memory, for each
// shifted entry. Search compares one entry at a time from index 0 and stops at
// the first match. The response sits in an output register, so the next
// request is taken while it waits. Entries come up undefined after reset; no
// clearing pass is run since only written entries are read.

module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pls_req_if.sink   i_req,
    pls_rsp_if.source o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    assign i_req.ready = w_ready;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_req.action),
        .i_position    (i_req.position),
        .i_value       (i_req.value),
        .i_search_key  (i_req.search_key),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_read_value  (o_rsp.read_value),
        .o_found_index (o_rsp.found_index),
        .o_fill_count  (o_rsp.fill_count)
    );

endmodule

// File: rtl/pls_datapath.sv
`timescale 1ns / 1ps

module pls_datapath
    import pls_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_search_key,
    input  logic               i_rsp_ready,
    output logic               o_rsp_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic signed [7:0]  o_found_index,
    output logic [7:0]         o_fill_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > 8) ? CW : 8;

    logic [2:0]         r_act;
    logic [7:0]         r_pos;
    logic signed [31:0] r_val;
    logic signed [31:0] r_key;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rdata;
    logic               r_ov;
    logic [1:0]         r_status;
    logic signed [31:0] r_read;
    logic signed [7:0]  r_fidx;
    logic [7:0]         r_fill;

    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      idx_x;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    assign pos_x = XW'(r_pos);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_idx);

    always_comb begin
        o_stat.act           = r_act;
        o_stat.full          = (r_count == CW'(CAPACITY));
        o_stat.ins_bad       = (pos_x > cnt_x);
        o_stat.pos_bad       = (pos_x >= cnt_x);
        o_stat.idx_gt_pos    = (idx_x > pos_x);
        o_stat.idx_p1_lt_cnt = (XW'(idx_x + XW'(1)) < cnt_x);
        o_stat.idx_lt_cnt    = (idx_x < cnt_x);
        o_stat.match         = (r_rdata == r_key);
        o_stat.out_free      = !r_ov || i_rsp_ready;
    end

    always_comb begin
        case (i_cmd.idx_sel)
            IDX_HOLD: n_idx = r_idx;
            IDX_POS:  n_idx = CW'(r_pos);
            IDX_CNT:  n_idx = r_count;
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = CW'(r_idx + 1'b1);
            IDX_DEC:  n_idx = CW'(r_idx - 1'b1);
            default:  n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:    rd_addr = AW'(r_idx);
            RD_IDX_M1: rd_addr = AW'(r_idx - 1'b1);
            RD_IDX_P1: rd_addr = AW'(r_idx + 1'b1);
            RD_POS:    rd_addr = AW'(r_pos);
            default:   rd_addr = AW'(r_idx);
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_CNT_VAL: begin
                wr_addr = AW'(r_count);
                wr_data = r_val;
            end
            WR_POS_VAL: begin
                wr_addr = AW'(r_pos);
                wr_data = r_val;
            end
            WR_IDX_RD: begin
                wr_addr = AW'(r_idx);
                wr_data = r_rdata;
            end
            default: begin
                wr_addr = AW'(r_idx);
                wr_data = r_rdata;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_HOLD: n_count = r_count;
            CNT_INC:  n_count = CW'(r_count + 1'b1);
            CNT_DEC:  n_count = CW'(r_count - 1'b1);
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= i_value;
            r_key <= i_search_key;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_read   <= i_cmd.out_read ? r_rdata : '0;
            r_fill   <= 8'(n_count);
            case (i_cmd.out_fidx)
                FX_ZERO: r_fidx <= '0;
                FX_IDX:  r_fidx <= 8'(r_idx);
                FX_NONE: r_fidx <= FIDX_NONE;
                default: r_fidx <= '0;
            endcase
        end
    end

    assign o_rsp_valid   = r_ov;
    assign o_status      = r_status;
    assign o_read_value  = r_read;
    assign o_found_index = r_fidx;
    assign o_fill_count  = r_fill;

endmodule

// File: rtl/pls_ctrl.sv
`timescale 1ns / 1ps

module pls_ctrl
    import pls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_DEL_CHK = 4'd4;
    localparam logic [3:0] S_DEL_WR  = 4'd5;
    localparam logic [3:0] S_RD_DONE = 4'd6;
    localparam logic [3:0] S_SR_CHK  = 4'd7;
    localparam logic [3:0] S_SR_CMP  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.act)
                    ACT_APPEND: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.wr_en      = 1'b1;
                                o_cmd.wr_sel     = WR_CNT_VAL;
                                o_cmd.cnt_op     = CNT_INC;
                                o_cmd.out_status = ST_OK;
                            end
                        end
                    end
                    ACT_INSERT: begin
                        if (i_stat.full || i_stat.ins_bad) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = i_stat.full ? ST_FULL : ST_BADPOS;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_sel = IDX_CNT;
                            n_state       = S_INS_CHK;
                        end
                    end
                    ACT_DELETE, ACT_READ: begin
                        if (i_stat.pos_bad) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_BADPOS;
                                n_state          = S_IDLE;
                            end
                        end else if (i_stat.act == ACT_DELETE) begin
                            o_cmd.idx_sel = IDX_POS;
                            n_state       = S_DEL_CHK;
                        end else begin
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_RD_DONE;
                        end
                    end
                    ACT_WRITE: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                            if (i_stat.pos_bad) begin
                                o_cmd.out_status = ST_BADPOS;
                            end else begin
                                o_cmd.wr_en      = 1'b1;
                                o_cmd.wr_sel     = WR_POS_VAL;
                                o_cmd.out_status = ST_OK;
                            end
                        end
                    end
                    ACT_SEARCH: begin
                        o_cmd.idx_sel = IDX_ZERO;
                        n_state       = S_SR_CHK;
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = ST_OK;
                            n_state          = S_IDLE;
                        end
                    end
                endcase
            end
            S_INS_CHK: begin
                if (i_stat.idx_gt_pos) begin
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = S_INS_WR;
                end else if (i_stat.out_free) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_sel     = WR_POS_VAL;
                    o_cmd.cnt_op     = CNT_INC;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_IDX_RD;
                o_cmd.idx_sel = IDX_DEC;
                n_state       = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (i_stat.idx_p1_lt_cnt) begin
                    o_cmd.rd_sel = RD_IDX_P1;
                    n_state      = S_DEL_WR;
                end else if (i_stat.out_free) begin
                    o_cmd.cnt_op     = CNT_DEC;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_IDX_RD;
                o_cmd.idx_sel = IDX_INC;
                n_state       = S_DEL_CHK;
            end
            S_RD_DONE: begin
                o_cmd.rd_sel = RD_POS;
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_read   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SR_CHK: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SR_CMP;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_NOTFOUND;
                    o_cmd.out_fidx   = FX_NONE;
                    n_state          = S_IDLE;
                end
            end
            S_SR_CMP: begin
                o_cmd.rd_sel = RD_IDX;
                if (!i_stat.match) begin
                    o_cmd.idx_sel = IDX_INC;
                    n_state       = S_SR_CHK;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_fidx   = FX_IDX;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/pls_checker.sv
`timescale 1ns / 1ps

module pls_checker
    import pls_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [1:0]         i_status,
    input logic signed [31:0] i_read_value,
    input logic signed [7:0]  i_found_index,
    input logic [7:0]         i_fill_count
);

    // one request in flight: no transaction right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted back to back");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_read_value) && $stable(i_found_index)
            && $stable(i_fill_count))
        else $error("stalled response changed");

    a_notfound_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_NOTFOUND |-> i_found_index == FIDX_NONE)
        else $error("not found without index -1");

    a_read_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_read_value != 32'sd0 |-> i_status == ST_OK)
        else $error("read data on failed request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_FULL |-> i_fill_count == 8'(CAPACITY))
        else $error("full reported below capacity");

endmodule

bind positional_list_store pls_checker #(
    .CAPACITY (CAPACITY)
) u_pls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_read_value  (o_rsp.read_value),
    .i_found_index (o_rsp.found_index),
    .i_fill_count  (o_rsp.fill_count)
);

// File: test/positional_list_store_test.sv
`timescale 1ns / 1ps

module positional_list_store_test;
    import pls_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam int HOLD_CYCLES = 400;
    localparam int CHUNK_ITEMS = 130;

    typedef struct {
        logic [2:0]         action;
        logic [7:0]         position;
        logic signed [31:0] value;
        logic signed [31:0] search_key;
    } list_req_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic signed [7:0]  found_index;
        logic [7:0]         fill_count;
    } list_rsp_t;

    typedef struct {
        logic signed [31:0] words [CAPACITY];
        int                 cnt;
    } list_state_t;

    logic i_clk;
    logic i_rst_n;

    pls_req_if req_if ();
    pls_rsp_if rsp_if ();

    positional_list_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    list_req_t   request_backlog [$];
    list_rsp_t   awaited_results [$];
    list_state_t dut_image;
    list_state_t plan_image;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          mismatch_count;
    bit          growing;

    function automatic list_rsp_t apply_request(input list_req_t r, inout list_state_t s);
        list_rsp_t rsp;
        int        pos;
        int        i;
        bit        hit;
        rsp.status      = ST_OK;
        rsp.read_value  = '0;
        rsp.found_index = '0;
        pos = int'(r.position);
        hit = 1'b0;
        case (r.action)
            ACT_APPEND: begin
                if (s.cnt >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    s.words[s.cnt] = r.value;
                    s.cnt++;
                end
            end
            ACT_INSERT: begin
                if (s.cnt >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else if (pos > s.cnt) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (i = s.cnt; i > pos; i--) s.words[i] = s.words[i - 1];
                    s.words[pos] = r.value;
                    s.cnt++;
                end
            end
            ACT_DELETE: begin
                if (pos >= s.cnt) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (i = pos; i + 1 < s.cnt; i++) s.words[i] = s.words[i + 1];
                    s.cnt--;
                end
            end
            ACT_READ: begin
                if (pos >= s.cnt) rsp.status = ST_BADPOS;
                else rsp.read_value = s.words[pos];
            end
            ACT_WRITE: begin
                if (pos >= s.cnt) rsp.status = ST_BADPOS;
                else s.words[pos] = r.value;
            end
            ACT_SEARCH: begin
                rsp.status      = ST_NOTFOUND;
                rsp.found_index = FIDX_NONE;
                for (i = 0; i < s.cnt && !hit; i++) begin
                    if (s.words[i] == r.search_key) begin
                        hit             = 1'b1;
                        rsp.status      = ST_OK;
                        rsp.found_index = 8'(i);
                    end
                end
            end
            default: ;
        endcase
        rsp.fill_count = 8'(s.cnt);
        return rsp;
    endfunction

    function automatic logic signed [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return 32'($signed($urandom_range(15)) - 8);
        if (roll < 40) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'shffff_ffff;
                default: return 32'sh0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_position(input int limit);
        if (limit > 0 && $urandom_range(99) < 85) return 8'($urandom_range(limit - 1));
        if ($urandom_range(1)) return 8'(limit);
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [2:0] pick_action();
        int roll;
        roll = $urandom_range(99);
        if (roll >= 98) return $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
        if (growing) begin
            if (roll < 30) return ACT_APPEND;
            if (roll < 60) return ACT_INSERT;
            if (roll < 70) return ACT_DELETE;
            if (roll < 80) return ACT_READ;
            if (roll < 88) return ACT_WRITE;
            return ACT_SEARCH;
        end
        if (roll < 55) return ACT_DELETE;
        if (roll < 60) return ACT_APPEND;
        if (roll < 65) return ACT_INSERT;
        if (roll < 77) return ACT_READ;
        if (roll < 85) return ACT_WRITE;
        return ACT_SEARCH;
    endfunction

    function automatic list_req_t pick_item();
        list_req_t r;
        r.action     = pick_action();
        r.value      = pick_word();
        r.search_key = pick_word();
        if (r.action == ACT_INSERT) r.position = pick_position(plan_image.cnt + 1);
        else r.position = pick_position(plan_image.cnt);
        if (r.action == ACT_SEARCH && plan_image.cnt > 0 && $urandom_range(1))
            r.search_key = plan_image.words[$urandom_range(plan_image.cnt - 1)];
        return r;
    endfunction

    task automatic queue_item(input list_req_t r);
        void'(apply_request(r, plan_image));
        request_backlog.push_back(r);
    endtask

    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) begin
            if (plan_image.cnt >= CAPACITY && $urandom_range(7) == 0) growing = 1'b0;
            if (plan_image.cnt <= 2) growing = 1'b1;
            queue_item(pick_item());
        end
    endtask

    task automatic wait_drained();
        while (request_backlog.size() > 0 || awaited_results.size() > 0 || req_if.valid)
            @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = '0;
        req_if.position   = '0;
        req_if.value      = '0;
        req_if.search_key = '0;
        rsp_if.ready      = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // driver: predicts each accepted transaction, then offers the next one
    always @(posedge i_clk) begin
        list_req_t acc;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                acc.action     = req_if.action;
                acc.position   = req_if.position;
                acc.value      = req_if.value;
                acc.search_key = req_if.search_key;
                awaited_results.push_back(apply_request(acc, dut_image));
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    acc = request_backlog.pop_front();
                    req_if.action     <= acc.action;
                    req_if.position   <= acc.position;
                    req_if.value      <= acc.value;
                    req_if.search_key <= acc.search_key;
                    req_if.valid      <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        list_rsp_t want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, rsp_if.read_value);
                        mismatch_count++;
                    end
                    if (rsp_if.found_index !== want.found_index) begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, rsp_if.found_index);
                        mismatch_count++;
                    end
                    if (rsp_if.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, rsp_if.fill_count);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        mismatch_count = 0;
        growing        = 1'b1;
        dut_image.cnt  = 0;
        plan_image.cnt = 0;
        for (int k = 0; k < CAPACITY; k++) begin
            dut_image.words[k]  = '0;
            plan_image.words[k] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        // empty list
        queue_item('{ACT_SEARCH, 8'd0, 32'sh0, 32'sh5});
        queue_item('{ACT_READ, 8'd0, 32'sh0, 32'sh0});
        queue_item('{ACT_DELETE, 8'd0, 32'sh0, 32'sh0});
        queue_item('{ACT_WRITE, 8'd0, 32'sh1, 32'sh0});
        queue_item('{ACT_INSERT, 8'd1, 32'sh1, 32'sh0});
        // build, edges and middle
        queue_item('{ACT_INSERT, 8'd0, 32'sh8000_0000, 32'sh0});
        queue_item('{ACT_APPEND, 8'd0, 32'sh7fff_ffff, 32'sh0});
        queue_item('{ACT_APPEND, 8'd0, 32'sh0, 32'sh0});
        queue_item('{ACT_INSERT, 8'd3, 32'shffff_ffff, 32'sh0});
        queue_item('{ACT_INSERT, 8'd1, 32'sh7fff_ffff, 32'sh0});
        // duplicate key reports the lowest index
        queue_item('{ACT_SEARCH, 8'd0, 32'sh0, 32'sh7fff_ffff});
        queue_item('{ACT_SEARCH, 8'd0, 32'sh0, 32'sh1234_5678});
        queue_item('{ACT_READ, 8'd4, 32'sh0, 32'sh0});
        queue_item('{ACT_WRITE, 8'd0, 32'sh55aa_55aa, 32'sh0});
        queue_item('{ACT_READ, 8'd0, 32'sh0, 32'sh0});
        // positions at and past the end, deletes and spare action codes
        queue_item('{ACT_DELETE, 8'd5, 32'sh0, 32'sh0});
        queue_item('{ACT_READ, 8'd5, 32'sh0, 32'sh0});
        queue_item('{ACT_DELETE, 8'd1, 32'sh0, 32'sh0});
        queue_item('{ACT_READ, 8'd255, 32'sh0, 32'sh0});
        queue_item('{ACT_INSERT, 8'd255, 32'sh1, 32'sh0});
        queue_item('{ACT_SPARE6, 8'd2, 32'sh1, 32'sh1});
        queue_item('{ACT_SPARE7, 8'd255, 32'shffff_ffff, 32'shffff_ffff});
        queue_item('{ACT_DELETE, 8'd0, 32'sh0, 32'sh0});
        queue_item('{ACT_SEARCH, 8'd0, 32'sh0, 32'shffff_ffff});
        queue_random(CHUNK_ITEMS);
        wait_drained();

        set_idling(58, 0);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        set_idling(0, 58);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        set_idling(30, 30);
        queue_random(CHUNK_ITEMS);
        wait_drained();

        // receiver holds off while the sender keeps offering
        set_idling(0, 0);
        hold_left = HOLD_CYCLES;
        queue_random(CHUNK_ITEMS);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
